### rtl/core/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types and constants of the diagonal curvature preconditioner.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int unsigned MaxParams = 16384;
  localparam int unsigned IdxW      = $clog2(MaxParams);
  localparam int unsigned CntW      = IdxW + 1;

  localparam logic [16:0] AlphaDefault   = 17'd6554;
  localparam logic [16:0] AlphaOne       = 17'd65536;
  localparam logic [31:0] DampingDefault = 32'd7;
  localparam logic [30:0] MaxStepDefault = 31'd6554;

  // register indexes of the configuration port
  localparam logic [1:0] RegNumParams = 2'd0;
  localparam logic [1:0] RegEmaAlpha  = 2'd1;
  localparam logic [1:0] RegDamping   = 2'd2;
  localparam logic [1:0] RegMaxStep   = 2'd3;

  typedef enum logic [0:0] {
    ReqUpdate = 1'b0,
    ReqApply  = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    StatusOk    = 1'b0,
    StatusError = 1'b1
  } status_e;

  typedef struct packed {
    logic        req_type;
    logic [13:0] param_index;
    logic [31:0] grad_value;
  } req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        status;
  } rsp_t;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StRead,
    StMulSq,
    StMulH,
    StRound,
    StWrite,
    StSqrt,
    StDenom,
    StDiv,
    StClamp,
    StOut
  } state_e;

endpackage

### rtl/core/diag_curvature_preconditioner.sv
// ----------------------------------------------------------------------------
// diag_curvature_preconditioner
// RMSProp-style per-parameter curvature store with bit-serial arithmetic.
// ----------------------------------------------------------------------------
// One item is in flight at a time. After reset a clearing pass writes zero to
// all 16384 store entries, one a cycle, before the first item is accepted.
// An update item goes through one store read, a 32-step shift-add square of
// the gradient, then 34 steps for the two 17-bit blend products alpha*sq and
// (1-alpha)*h, a round and a write back, and then has its result valid. An
// apply item goes through read, setup, a 2-bit-per-step square root over 32
// steps, the denominator add, a restoring divide over 48 quotient bits (one
// a cycle) and the clamp. A rejected item has its result valid on the next
// cycle. The next item is accepted in the cycle after the result transfer.
module diag_curvature_preconditioner
  import dcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o
);

  // configuration registers
  logic [CntW-1:0] num_params_q;
  logic [16:0]     ema_alpha_q;
  logic [31:0]     damping_q;
  logic [30:0]     max_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_params_q <= '0;
      ema_alpha_q  <= AlphaDefault;
      damping_q    <= DampingDefault;
      max_step_q   <= MaxStepDefault;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegNumParams: num_params_q <= cfg_data_i[CntW-1:0];
        RegEmaAlpha:  ema_alpha_q  <= cfg_data_i[16:0];
        RegDamping:   damping_q    <= cfg_data_i;
        RegMaxStep:   max_step_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // effective alpha and step limit
  logic [16:0] alpha;
  logic [30:0] mstep;
  assign alpha = (ema_alpha_q == '0 || ema_alpha_q > AlphaOne) ? AlphaDefault : ema_alpha_q;
  assign mstep = (max_step_q == '0) ? MaxStepDefault : max_step_q;

  // curvature store
  logic [31:0] store_q [MaxParams];
  logic [31:0] rd_data_q;
  logic        st_we;
  logic [IdxW-1:0] st_addr;
  logic [31:0] st_wdata;

  always_ff @(posedge clk_i) begin
    if (st_we) store_q[st_addr] <= st_wdata;
    rd_data_q <= store_q[st_addr];
  end

  // control and datapath registers
  state_e state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        type_q, type_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;
  logic [31:0] h_q, h_d;
  // shared accumulators: product / remainder and operand shifters
  logic [79:0] acc_q, acc_d;
  logic [63:0] opa_q, opa_d;
  logic [63:0] opb_q, opb_d;
  logic [32:0] den_q, den_d;
  logic        out_valid_q, out_valid_d;
  rsp_t        out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    type_q <= type_d;
    idx_q  <= idx_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    h_q    <= h_d;
    acc_q  <= acc_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    den_q  <= den_d;
    out_q  <= out_d;
  end

  logic        bad_idx;
  logic [31:0] g;
  logic [65:0] sq_trial;
  logic [64:0] div_trial;
  logic [63:0] q_full;
  logic [47:0] nh;

  assign g       = in_data_i.grad_value;
  assign bad_idx = (num_params_q == '0) || ({1'b0, in_data_i.param_index} >= num_params_q);

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    type_d      = type_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    h_d         = h_q;
    acc_d       = acc_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    den_d       = den_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    st_we       = 1'b0;
    st_addr     = idx_q;
    st_wdata    = '0;
    sq_trial    = '0;
    div_trial   = '0;
    q_full      = '0;
    nh          = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      StClear: begin
        st_we   = 1'b1;
        st_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IdxW'(MaxParams - 1)) state_d = StIdle;
      end
      StIdle: begin
        st_addr = in_data_i.param_index;
        if (in_valid_i && in_ready_o) begin
          type_d = in_data_i.req_type;
          idx_d  = in_data_i.param_index;
          neg_d  = g[31];
          mag_d  = g[31] ? (32'd0 - g) : g;
          if (bad_idx) begin
            out_d       = '{result_value: '0, status: StatusError};
            out_valid_d = 1'b1;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: begin
        // store data arrives next cycle
        state_d = StMulSq;
        acc_d   = '0;
        opa_d   = {32'd0, mag_q};
        opb_d   = {32'd0, mag_q};
        cnt_d   = '0;
      end
      StMulSq: begin
        if (cnt_q == '0) h_d = rd_data_q;
        if (type_q == ReqApply && cnt_q == '0) begin
          // set up the root: radicand h<<16 in opa, root in opb, rem in acc
          opa_d   = {16'd0, rd_data_q, 16'd0};
          opb_d   = '0;
          acc_d   = '0;
          state_d = StSqrt;
        end else begin
          // square: one multiplier bit per cycle
          if (opb_q[0]) acc_d = acc_q + {16'd0, opa_q};
          opa_d = opa_q << 1;
          opb_d = opb_q >> 1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == 7'd31) begin
            // sq = product >> 16, now blend: acc = alpha*sq; h term later
            opa_d   = {16'd0, acc_d[63:16]};
            opb_d   = {47'd0, alpha};
            acc_d   = '0;
            cnt_d   = '0;
            state_d = StMulH;
          end
        end
      end
      StMulH: begin
        // two serial products: alpha*sq then (65536-alpha)*h
        if (opb_q[0]) acc_d = acc_q + {16'd0, opa_q};
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 7'd16) begin
          opa_d = {32'd0, h_q};
          opb_d = {47'd0, AlphaOne - alpha};
        end
        if (cnt_q == 7'd33) state_d = StRound;
      end
      StRound: begin
        nh      = acc_q[63:16] + {47'd0, acc_q[15]};
        h_d     = (nh[47:32] != '0) ? 32'hFFFF_FFFF : nh[31:0];
        state_d = StWrite;
      end
      StWrite: begin
        st_we       = 1'b1;
        st_wdata    = h_q;
        out_d       = '{result_value: '0, status: StatusOk};
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      StSqrt: begin
        // two radicand bits per cycle, 32 steps
        sq_trial = {acc_q[63:0], opa_q[63:62]} - {opb_q[63:0], 2'b01};
        opa_d    = opa_q << 2;
        if (!sq_trial[65]) begin
          acc_d = {16'd0, sq_trial[63:0]};
          opb_d = {opb_q[62:0], 1'b1};
        end else begin
          acc_d = {14'd0, acc_q[63:0], opa_q[63:62]};
          opb_d = {opb_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 7'd31) state_d = StDenom;
      end
      StDenom: begin
        den_d   = {1'b0, opb_q[31:0]} + {1'b0, damping_q};
        opa_d   = {16'd0, mag_q, 16'd0};
        acc_d   = '0;
        opb_d   = '0;
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        // restoring divide, one quotient bit per cycle over 48 dividend bits
        div_trial = {acc_q[63:0], opa_q[47]} - {32'd0, den_q};
        opa_d     = opa_q << 1;
        if (!div_trial[64]) begin
          acc_d = {16'd0, div_trial[63:0]};
          opb_d = {opb_q[62:0], 1'b1};
        end else begin
          acc_d = {15'd0, acc_q[63:0], opa_q[47]};
          opb_d = {opb_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 7'd47) state_d = StClamp;
      end
      StClamp: begin
        if (den_q == '0) q_full = (mag_q == '0) ? 64'd0 : {33'd0, mstep};
        else q_full = opb_q;
        if (q_full > {33'd0, mstep}) q_full = {33'd0, mstep};
        out_d.result_value = neg_q ? (32'd0 - q_full[31:0]) : q_full[31:0];
        out_d.status       = StatusOk;
        out_valid_d        = 1'b1;
        state_d            = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

### rtl/core/dcp_checker.sv
// ----------------------------------------------------------------------------
// dcp_checker
// Port-level assertions for the diagonal curvature preconditioner.
// ----------------------------------------------------------------------------
module dcp_checker
  import dcp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  // a held result stays put until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // no new input while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  // one item in flight: after a transfer in, ready drops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted");

  // an error result carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatusError |-> out_data_o.result_value == '0)
    else $error("error result with nonzero value");

endmodule

bind diag_curvature_preconditioner dcp_checker u_dcp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

### test/diag_curvature_preconditioner_test.sv
// ----------------------------------------------------------------------------
// diag_curvature_preconditioner_test
// Self-checking bench: a directed table, then random traffic checked against
// a local model of the curvature store, under sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diag_curvature_preconditioner_test;
  import dcp_pkg::*;

  localparam int unsigned StallLimit = 100000;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_val;
    req_t        req;
    logic        fixed;
    rsp_t        rsp;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  req_t        in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rsp_t        out_data_o;

  // typed expectation that travels with the offered item
  logic        cur_fixed;
  rsp_t        cur_rsp;

  // local copy of the block state
  logic [31:0] curv_mirror [MaxParams];
  logic [14:0] cnt_mirror;
  logic [16:0] alpha_mirror;
  logic [31:0] damp_mirror;
  logic [30:0] step_mirror;

  rsp_t        pending_rsp [$];
  stim_row_t   dir_rows [$];
  int          errors;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_req;
  int          hold_cnt;
  int          quiet_cycles;

  diag_curvature_preconditioner u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // floor square root of a 48-bit value, one result bit per step
  function automatic logic [23:0] isqrt48(input logic [47:0] x);
    logic [47:0] r;
    logic [47:0] t;
    r = '0;
    for (int i = 23; i >= 0; i--) begin
      t = r | (48'd1 << i);
      if (t * t <= x) r = t;
    end
    return r[23:0];
  endfunction

  // expected response of one item, updating the local store
  function automatic rsp_t precondition(input req_t rq);
    rsp_t        rs;
    logic        neg;
    logic [31:0] mag;
    logic [63:0] alpha;
    logic [63:0] mstep;
    logic [63:0] h;
    logic [63:0] sq;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] q;
    rs.result_value = '0;
    rs.status = StatusOk;
    neg = rq.grad_value[31];
    mag = neg ? (32'd0 - rq.grad_value) : rq.grad_value;
    alpha = (alpha_mirror == 0 || alpha_mirror > AlphaOne) ? 64'(AlphaDefault)
                                                           : 64'(alpha_mirror);
    mstep = (step_mirror == 0) ? 64'(MaxStepDefault) : 64'(step_mirror);
    if (cnt_mirror == 0 || 15'(rq.param_index) >= cnt_mirror) begin
      rs.status = StatusError;
      return rs;
    end
    h = 64'(curv_mirror[rq.param_index]);
    if (rq.req_type == ReqUpdate) begin
      sq = (64'(mag) * 64'(mag)) >> 16;
      s = alpha * sq + (64'd65536 - alpha) * h;
      s = (s + 64'd32768) >> 16;
      curv_mirror[rq.param_index] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    end else begin
      d = 64'(isqrt48({h[31:0], 16'd0})) + 64'(damp_mirror);
      if (d == 0) q = (mag == 0) ? 64'd0 : mstep;
      else q = (64'(mag) << 16) / d;
      if (q > mstep) q = mstep;
      rs.result_value = neg ? (32'd0 - q[31:0]) : q[31:0];
    end
    return rs;
  endfunction

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // receiver: random ready, with a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_req != 0 && hold_cnt == 0) begin
      hold_cnt <= hold_req;
      hold_req = 0;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // input transfers feed the model, output transfers are checked
  always @(posedge clk_i) begin
    rsp_t pred;
    rsp_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      pred = precondition(in_data_i);
      pending_rsp.push_back(cur_fixed ? cur_rsp : pred);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected transfer", out_data_o.result_value, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data_o.result_value !== want.result_value)
          report("result_value", out_data_o.result_value, want.result_value);
        if (out_data_o.status !== want.status)
          report("status", 32'(out_data_o.status), 32'(want.status));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("diag_curvature_preconditioner regression: fail");
      $finish;
    end
  end

  task automatic send(input req_t rq, input logic fixed, input rsp_t rs);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    cur_fixed <= fixed;
    cur_rsp <= rs;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // one edge first so that a transfer at the current edge is counted
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegNumParams: cnt_mirror = val[14:0];
      RegEmaAlpha:  alpha_mirror = val[16:0];
      RegDamping:   damp_mirror = val;
      default:      step_mirror = val[30:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_item(input req_e kind, input logic [13:0] idx,
                                   input logic [31:0] g, input logic fixed,
                                   input logic [31:0] val, input status_e st);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_idx = '0;
    row.cfg_val = '0;
    row.req = '{req_type: kind, param_index: idx, grad_value: g};
    row.fixed = fixed;
    row.rsp = '{result_value: val, status: st};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] val);
    stim_row_t row;
    row = '{is_cfg: 1'b1, cfg_idx: idx, cfg_val: val, req: '0, fixed: 1'b0,
            rsp: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'(MaxParams);
      2: return 32'h7FFF;
      3: return $urandom_range(1, MaxParams);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  // one random setting per segment, extremes included
  task automatic random_setting();
    write_reg(RegNumParams, rand_count());
    case ($urandom_range(4))
      0: write_reg(RegEmaAlpha, 32'(AlphaOne));
      1: write_reg(RegEmaAlpha, 32'd0);
      2: write_reg(RegEmaAlpha, 32'h1FFFF);
      default: write_reg(RegEmaAlpha, $urandom_range(1, 65536));
    endcase
    case ($urandom_range(4))
      0: write_reg(RegDamping, 32'd0);
      1: write_reg(RegDamping, 32'hFFFF_FFFF);
      2: write_reg(RegDamping, $urandom);
      default: write_reg(RegDamping, $urandom_range(0, 1 << 16));
    endcase
    case ($urandom_range(4))
      0: write_reg(RegMaxStep, 32'd0);
      1: write_reg(RegMaxStep, 32'h7FFF_FFFF);
      2: write_reg(RegMaxStep, $urandom);
      default: write_reg(RegMaxStep, $urandom_range(1, 1 << 20));
    endcase
  endtask

  // stimulus
  initial begin
    req_t        rq;
    logic [13:0] base;
    logic [31:0] limit;
    errors = 0;
    quiet_cycles = 0;
    hold_req = 0;
    tx_idle_pct = 15;
    rx_idle_pct = 61;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    cur_fixed = 1'b0;
    cur_rsp = '0;
    foreach (curv_mirror[i]) curv_mirror[i] = '0;
    cnt_mirror = '0;
    alpha_mirror = AlphaDefault;
    damp_mirror = DampingDefault;
    step_mirror = MaxStepDefault;

    // not initialized
    add_item(ReqApply, 14'd0, 32'd1, 1'b1, 32'd0, StatusError);
    add_item(ReqUpdate, 14'd0, 32'd1, 1'b1, 32'd0, StatusError);
    // empty store with reset damping clamps to the default step
    add_cfg(RegNumParams, 32'(MaxParams));
    add_item(ReqApply, 14'd0, 32'h0001_0000, 1'b1, 32'd6554, StatusOk);
    add_item(ReqApply, 14'h3FFF, 32'h8000_0000, 1'b1, 32'hFFFF_E666, StatusOk);
    // zero denominator by sign of the gradient
    add_cfg(RegDamping, 32'd0);
    add_item(ReqApply, 14'd5, 32'd5, 1'b1, 32'd6554, StatusOk);
    add_item(ReqApply, 14'd5, 32'hFFFF_FFFB, 1'b1, 32'hFFFF_E666, StatusOk);
    add_item(ReqApply, 14'd5, 32'd0, 1'b1, 32'd0, StatusOk);
    // zero max step falls back to the default
    add_cfg(RegMaxStep, 32'd0);
    add_item(ReqApply, 14'd6, 32'd1, 1'b1, 32'd6554, StatusOk);
    add_cfg(RegMaxStep, 32'h7FFF_FFFF);
    add_item(ReqApply, 14'd6, 32'd1, 1'b1, 32'h7FFF_FFFF, StatusOk);
    add_item(ReqUpdate, 14'd7, 32'h7FFF_FFFF, 1'b0, 32'd0, StatusOk);
    add_item(ReqUpdate, 14'd7, 32'h8000_0000, 1'b0, 32'd0, StatusOk);
    add_item(ReqApply, 14'd7, 32'h7FFF_FFFF, 1'b0, 32'd0, StatusOk);
    // full weight saturates the entry
    add_cfg(RegEmaAlpha, 32'(AlphaOne));
    add_item(ReqUpdate, 14'd8, 32'h8000_0000, 1'b1, 32'd0, StatusOk);
    add_item(ReqApply, 14'd8, 32'h7FFF_FFFF, 1'b0, 32'd0, StatusOk);
    // out-of-range alpha acts as the default
    add_cfg(RegEmaAlpha, 32'd0);
    add_item(ReqUpdate, 14'd9, 32'h1234_5678, 1'b0, 32'd0, StatusOk);
    add_cfg(RegEmaAlpha, 32'h1FFFF);
    add_item(ReqUpdate, 14'd9, 32'hEDCB_A988, 1'b0, 32'd0, StatusOk);
    add_item(ReqApply, 14'd9, 32'h0000_4000, 1'b0, 32'd0, StatusOk);
    // index range and count change
    add_cfg(RegNumParams, 32'd100);
    add_item(ReqApply, 14'd100, 32'd1, 1'b1, 32'd0, StatusError);
    add_item(ReqUpdate, 14'd99, 32'h0003_0000, 1'b0, 32'd0, StatusOk);
    add_item(ReqUpdate, 14'h3FFF, 32'd1, 1'b1, 32'd0, StatusError);
    add_cfg(RegDamping, 32'hFFFF_FFFF);
    add_item(ReqApply, 14'd99, 32'h7FFF_FFFF, 1'b0, 32'd0, StatusOk);
    add_cfg(RegNumParams, 32'h7FFF);
    add_item(ReqApply, 14'd9, 32'h8000_0001, 1'b0, 32'd0, StatusOk);
    add_item(ReqApply, 14'h3FFF, 32'hFFFF_0000, 1'b0, 32'd0, StatusOk);

    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      else send(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);
    end

    // random part: three idling modes, five settings each
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 61 : 0;
      rx_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 15 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        random_setting();
        limit = (cnt_mirror == 0) ? 32'd1 : 32'(cnt_mirror);
        if (limit > MaxParams) limit = MaxParams;
        if (mode == 2 && seg == 0) hold_req = 400;
        for (int n = 0; n < 130; n++) begin
          // two in three updates, mixed at random with applies, mostly on a small window of entries
          base = (limit > 8) ? 14'($urandom_range(0, limit - 8)) : 14'd0;
          rq.req_type = ($urandom_range(2) == 0) ? ReqApply : ReqUpdate;
          if ($urandom_range(9) < 8)
            rq.param_index = base[13:0] & 14'h3FF8 | 14'($urandom_range(0, 7));
          else
            rq.param_index = 14'($urandom);
          rq.grad_value = rand_grad();
          if (mode == 1 && seg == 2 && n == 60) drain();
          send(rq, 1'b0, '0);
        end
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("diag_curvature_preconditioner regression: pass");
    end else begin
      $display("diag_curvature_preconditioner regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/dcp_pkg.sv
rtl/core/diag_curvature_preconditioner.sv
rtl/core/dcp_checker.sv
test/diag_curvature_preconditioner_test.sv
